/* design/sbf_pkg.sv */
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared constants, payload types and the divide-by-three helper for the
// separable 3x3 box filter.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 16;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CH_W         = 8;
    localparam int SUM_W        = 10;
    localparam int STORE_W      = 6 * CH_W;

    // n/3 == (n*683) >> 11 for every n up to 3*255
    localparam int DIV3_MUL     = 683;
    localparam int DIV3_SHIFT   = 11;
    localparam int DIV3_PROD_W  = 20;

    localparam int FIFO_DEPTH   = 16;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
    localparam int MAX_RESULTS  = 4;
    localparam int RES_CNT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic [CH_W-1:0] pixel_red;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_blue;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            end_of_frame;
        logic            last_of_run;
    } t_result;

    // index 2 is red, 0 is blue
    typedef logic [2:0][CH_W-1:0]  t_rgb;
    typedef logic [2:0][SUM_W-1:0] t_sum3;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    // one horizontal mean on its way to the line stores
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] x;
        t_rgb              h;
        logic              row0;
        logic              row1;
        logic              last_row;
        logic              eof;
        logic              last_item;
    } t_event;

    typedef struct packed {
        logic    v0;
        t_result w0;
        logic    v1;
        t_result w1;
    } t_push;

    function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] n);
        logic [DIV3_PROD_W-1:0] prod;
        prod = DIV3_PROD_W'(n) * DIV3_PROD_W'(DIV3_MUL);
        return prod[DIV3_SHIFT +: CH_W];
    endfunction

endpackage

/* design/sbf_ram.sv */
// ----------------------------------------------------------------------------
// sbf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/sbf_front.sv */
// ----------------------------------------------------------------------------
// sbf_front
// Pixel intake: raster position, horizontal 3-tap sums, and the issue stage
// that sends one horizontal mean per cycle to the line-store update.
// ----------------------------------------------------------------------------
module sbf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sbf_pkg::t_pixel               i_pixel,
    input  logic [sbf_pkg::ADDR_W-1:0]    i_wm1,
    input  logic [sbf_pkg::ROW_W-1:0]     i_hm1,
    input  logic                          i_credit_ok,
    output logic                          o_stall,
    output logic                          o_accept,
    output logic [sbf_pkg::RES_CNT_W-1:0] o_res_cnt,
    output sbf_pkg::t_rd_req              o_rd_req,
    output sbf_pkg::t_event               o_event
);

    typedef struct packed {
        logic [sbf_pkg::ADDR_W-1:0] x;
        sbf_pkg::t_sum3             sum;
        logic                       row0;
        logic                       row1;
        logic                       last_row;
    } t_slot;

    logic [sbf_pkg::ADDR_W-1:0] r_col;
    logic [sbf_pkg::ROW_W-1:0]  r_row;
    sbf_pkg::t_rgb              r_prev;
    sbf_pkg::t_rgb              r_prev2;
    logic                       r_a_valid;
    logic                       r_b_valid;
    t_slot                      r_a;
    t_slot                      r_b;
    sbf_pkg::t_event            r_event;

    logic [sbf_pkg::ADDR_W-1:0] c;
    logic [sbf_pkg::ROW_W-1:0]  r;
    logic                       last_col;
    logic                       last_row;
    logic                       has_a;
    sbf_pkg::t_rgb              cur;
    t_slot                      n_a;
    t_slot                      n_b;
    logic [1:0]                 nres;
    logic [1:0]                 ev_cnt;
    t_slot                      sel;
    sbf_pkg::t_event            n_event;

    always_comb begin
        c        = (r_col < i_wm1) ? r_col : i_wm1;
        r        = (r_row < i_hm1) ? r_row : i_hm1;
        last_col = (c == i_wm1);
        last_row = (r == i_hm1);
        has_a    = (c != '0);
        cur      = sbf_pkg::t_rgb'(i_pixel);

        n_a.x        = c - sbf_pkg::ADDR_W'(1);
        n_a.row0     = (r == '0);
        n_a.row1     = (r == sbf_pkg::ROW_W'(1));
        n_a.last_row = last_row;
        n_b.x        = c;
        n_b.row0     = n_a.row0;
        n_b.row1     = n_a.row1;
        n_b.last_row = last_row;
        for (int ch = 0; ch < 3; ch++) begin
            // left neighbor clamps to the edge on column one
            n_a.sum[ch] = ((c == sbf_pkg::ADDR_W'(1)) ? sbf_pkg::SUM_W'(r_prev[ch])
                                                       : sbf_pkg::SUM_W'(r_prev2[ch]))
                        + sbf_pkg::SUM_W'(r_prev[ch]) + sbf_pkg::SUM_W'(cur[ch]);
            n_b.sum[ch] = (has_a ? sbf_pkg::SUM_W'(r_prev[ch]) : sbf_pkg::SUM_W'(cur[ch]))
                        + {sbf_pkg::SUM_W'(cur[ch]) << 1};
        end

        // results per horizontal mean, then per pixel
        if (n_a.row0) begin
            nres = last_row ? 2'd1 : 2'd0;
        end else begin
            nres = last_row ? 2'd2 : 2'd1;
        end
        ev_cnt = 2'(has_a) + 2'(last_col);
        case (nres)
            2'd1:    o_res_cnt = sbf_pkg::RES_CNT_W'(ev_cnt);
            2'd2:    o_res_cnt = sbf_pkg::RES_CNT_W'(ev_cnt) << 1;
            default: o_res_cnt = '0;
        endcase
    end

    // a pixel at the end of a row wider than one pixel leaves two updates; only one retires per cycle
    assign o_stall  = (r_a_valid && r_b_valid) || !i_credit_ok;
    assign o_accept = i_valid && !o_stall;

    // issue stage: column x-1 update goes before column x
    always_comb begin
        sel               = r_a_valid ? r_a : r_b;
        n_event.valid     = r_a_valid || r_b_valid;
        n_event.x         = sel.x;
        n_event.row0      = sel.row0;
        n_event.row1      = sel.row1;
        n_event.last_row  = sel.last_row;
        n_event.eof       = !r_a_valid;
        n_event.last_item = !(r_a_valid && r_b_valid);
        for (int ch = 0; ch < 3; ch++) begin
            n_event.h[ch] = sbf_pkg::div3(sel.sum[ch]);
        end
    end

    assign o_rd_req.en   = n_event.valid;
    assign o_rd_req.addr = n_event.x;
    assign o_event       = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_prev    <= '0;
            r_prev2   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_event   <= '0;
        end else begin
            r_event <= n_event;
            if (o_accept) begin
                r_a_valid <= has_a;
                r_b_valid <= last_col;
                r_a       <= n_a;
                r_b       <= n_b;
                r_prev2   <= r_prev;
                r_prev    <= cur;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r + sbf_pkg::ROW_W'(1);
                end else begin
                    r_col <= c + sbf_pkg::ADDR_W'(1);
                    r_row <= r;
                end
            end else if (r_a_valid) begin
                r_a_valid <= 1'b0;
            end else begin
                r_b_valid <= 1'b0;
            end
        end
    end

endmodule

/* design/sbf_vert.sv */
// ----------------------------------------------------------------------------
// sbf_vert
// Line-store read-modify-write and the vertical 3-tap mean. One RAM entry per
// column holds the horizontal means of the two rows above.
// ----------------------------------------------------------------------------
module sbf_vert (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbf_pkg::t_rd_req i_rd_req,
    input  sbf_pkg::t_event  i_event,
    output sbf_pkg::t_push   o_push
);

    logic [sbf_pkg::STORE_W-1:0] rd_data;
    logic [sbf_pkg::STORE_W-1:0] wr_data;
    logic [sbf_pkg::STORE_W-1:0] stored;
    logic [sbf_pkg::STORE_W-1:0] r_fwd_data;
    logic                        r_fwd_hit;
    sbf_pkg::t_rgb               above;
    sbf_pkg::t_rgb               curr;
    sbf_pkg::t_rgb               tap_a;
    sbf_pkg::t_sum3              s1;
    sbf_pkg::t_sum3              s2;

    logic            r_d_valid;
    sbf_pkg::t_sum3  r_d_s1;
    sbf_pkg::t_sum3  r_d_s2;
    sbf_pkg::t_rgb   r_d_h;
    logic            r_d_row0;
    logic            r_d_last_row;
    logic            r_d_eof;
    logic            r_d_last_item;

    sbf_pkg::t_rgb   res1;
    sbf_pkg::t_rgb   res2;

    sbf_ram #(
        .WIDTH (sbf_pkg::STORE_W),
        .DEPTH (sbf_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_event.valid),
        .i_wr_addr (i_event.x),
        .i_wr_data (wr_data),
        .i_rd_en   (i_rd_req.en),
        .i_rd_addr (i_rd_req.addr),
        .o_rd_data (rd_data)
    );

    // back-to-back hits on one column (one-pixel rows) bypass the RAM
    always_comb begin
        stored  = r_fwd_hit ? r_fwd_data : rd_data;
        above   = stored[sbf_pkg::STORE_W-1 -: 3*sbf_pkg::CH_W];
        curr    = stored[3*sbf_pkg::CH_W-1:0];
        wr_data = {curr, i_event.h};
        tap_a   = i_event.row1 ? curr : above;
        for (int ch = 0; ch < 3; ch++) begin
            s1[ch] = sbf_pkg::SUM_W'(tap_a[ch]) + sbf_pkg::SUM_W'(curr[ch])
                   + sbf_pkg::SUM_W'(i_event.h[ch]);
            s2[ch] = sbf_pkg::SUM_W'(curr[ch]) + {sbf_pkg::SUM_W'(i_event.h[ch]) << 1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_fwd_hit <= i_rd_req.en && i_event.valid && (i_rd_req.addr == i_event.x);
            r_d_valid <= i_event.valid;
        end
        r_fwd_data    <= wr_data;
        r_d_s1        <= s1;
        r_d_s2        <= s2;
        r_d_h         <= i_event.h;
        r_d_row0      <= i_event.row0;
        r_d_last_row  <= i_event.last_row;
        r_d_eof       <= i_event.eof;
        r_d_last_item <= i_event.last_item;
    end

    // on the last row of a frame two or more rows high each column gives the row above, then the last row
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            res1[ch] = sbf_pkg::div3(r_d_s1[ch]);
            res2[ch] = sbf_pkg::div3(r_d_s2[ch]);
        end
        o_push = '0;
        if (r_d_row0) begin
            o_push.v0              = r_d_valid && r_d_last_row;
            o_push.w0.out_red      = r_d_h[2];
            o_push.w0.out_green    = r_d_h[1];
            o_push.w0.out_blue     = r_d_h[0];
            o_push.w0.end_of_frame = r_d_eof;
            o_push.w0.last_of_run  = r_d_last_item;
        end else begin
            o_push.v0              = r_d_valid;
            o_push.w0.out_red      = res1[2];
            o_push.w0.out_green    = res1[1];
            o_push.w0.out_blue     = res1[0];
            o_push.w0.end_of_frame = 1'b0;
            o_push.w0.last_of_run  = r_d_last_item && !r_d_last_row;
            o_push.v1              = r_d_valid && r_d_last_row;
            o_push.w1.out_red      = res2[2];
            o_push.w1.out_green    = res2[1];
            o_push.w1.out_blue     = res2[0];
            o_push.w1.end_of_frame = r_d_eof;
            o_push.w1.last_of_run  = r_d_last_item;
        end
    end

endmodule

/* design/sbf_out_fifo.sv */
// ----------------------------------------------------------------------------
// sbf_out_fifo
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module sbf_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbf_pkg::t_push   i_push,
    input  logic             i_stall,
    output logic             o_valid,
    output sbf_pkg::t_result o_result,
    output logic             o_pop
);

    sbf_pkg::t_result                r_mem [sbf_pkg::FIFO_DEPTH];
    logic [sbf_pkg::FIFO_PTR_W-1:0]  r_wp;
    logic [sbf_pkg::FIFO_PTR_W-1:0]  r_rp;
    logic [sbf_pkg::FIFO_CNT_W-1:0]  r_cnt;
    logic [sbf_pkg::FIFO_PTR_W-1:0]  wp1;
    logic [1:0]                      n_push;

    assign o_valid  = (r_cnt != '0);
    assign o_pop    = o_valid && !i_stall;
    assign o_result = r_mem[r_rp];
    assign wp1      = r_wp + sbf_pkg::FIFO_PTR_W'(1);
    assign n_push   = 2'(i_push.v0) + 2'(i_push.v1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + sbf_pkg::FIFO_PTR_W'(n_push);
            r_rp  <= r_rp + sbf_pkg::FIFO_PTR_W'(o_pop);
            r_cnt <= r_cnt + sbf_pkg::FIFO_CNT_W'(n_push) - sbf_pkg::FIFO_CNT_W'(o_pop);
        end
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.w0;
        end
        if (i_push.v1) begin
            r_mem[wp1] <= i_push.w1;
        end
    end

endmodule

/* design/separable_box_filter_3x3_top.sv */
// Path: a result word passes the intake slots, the issue register and line-RAM
// read, the vertical-mean register and the result queue before it shows on o_valid.
// Throughput: one pixel per clock while the result queue has room; the last pixel
// of a row wider than one pixel stalls intake (two line-RAM updates on one port),
// and each pixel on the last row of a frame two or more rows high gives two words.
// Reset: control cleared, config back to 2048 x 1; line RAM is not cleared.
// ----------------------------------------------------------------------------
// separable_box_filter_3x3_top
// RGB888 3x3 separable box filter with edge clamping over a raster stream.
// ----------------------------------------------------------------------------
module separable_box_filter_3x3_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  sbf_pkg::t_pixel                 i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output sbf_pkg::t_result                o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [sbf_pkg::ADDR_W-1:0]     r_wm1;
    logic [sbf_pkg::ROW_W-1:0]      r_hm1;
    logic [sbf_pkg::FIFO_CNT_W-1:0] r_occ;
    logic [sbf_pkg::CFG_WIDTH_W-1:0] cfg_w;
    logic [sbf_pkg::ROW_W-1:0]      cfg_h;

    logic                           accept;
    logic [sbf_pkg::RES_CNT_W-1:0]  res_cnt;
    logic                           credit_ok;
    logic                           pop;
    sbf_pkg::t_rd_req               rd_req;
    sbf_pkg::t_event                ev;
    sbf_pkg::t_push                 push;

    assign o_cfg_ready = 1'b1;
    assign cfg_w       = i_cfg_data[sbf_pkg::CFG_WIDTH_W-1:0];
    assign cfg_h       = i_cfg_data[sbf_pkg::ROW_W-1:0];

    // queue slots reserved at intake, freed as words leave
    assign credit_ok = (r_occ <= sbf_pkg::FIFO_CNT_W'(sbf_pkg::FIFO_DEPTH - sbf_pkg::MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= sbf_pkg::ADDR_W'(sbf_pkg::MAX_WIDTH - 1);
            r_hm1 <= '0;
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + (accept ? sbf_pkg::FIFO_CNT_W'(res_cnt) : '0)
                   - sbf_pkg::FIFO_CNT_W'(pop);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sbf_pkg::REG_FRAME_WIDTH: begin
                        if (cfg_w == '0) begin
                            r_wm1 <= '0;
                        end else if (32'(cfg_w) > 32'(sbf_pkg::MAX_WIDTH)) begin
                            r_wm1 <= sbf_pkg::ADDR_W'(sbf_pkg::MAX_WIDTH - 1);
                        end else begin
                            r_wm1 <= sbf_pkg::ADDR_W'(cfg_w - sbf_pkg::CFG_WIDTH_W'(1));
                        end
                    end
                    sbf_pkg::REG_FRAME_HEIGHT: begin
                        r_hm1 <= (cfg_h == '0) ? '0 : cfg_h - sbf_pkg::ROW_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    sbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .i_wm1       (r_wm1),
        .i_hm1       (r_hm1),
        .i_credit_ok (credit_ok),
        .o_stall     (o_stall),
        .o_accept    (accept),
        .o_res_cnt   (res_cnt),
        .o_rd_req    (rd_req),
        .o_event     (ev)
    );

    sbf_vert u_vert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_req (rd_req),
        .i_event  (ev),
        .o_push   (push)
    );

    sbf_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_pop    (pop)
    );

endmodule
